>>> src/button_long_double_press_detector_macros.svh
// Assertion macros for the button long/double press detector.
// Included by the RTL modules that carry concurrent checks; no other dependencies.
`ifndef BUTTON_LONG_DOUBLE_PRESS_DETECTOR_MACROS_SVH
`define BUTTON_LONG_DOUBLE_PRESS_DETECTOR_MACROS_SVH

// Implication check, sampled on the rising clock, off while reset is held
`define BLDP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true on a sampled clock edge
`define BLDP_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/bldp_pkg.sv
// Shared types and constants for the button long/double press detector.
// Used by bldp_core, bldp_out_buf and the top level; no dependencies.
`default_nettype none

package bldp_pkg;

  // Counter width default and register widths
  localparam int unsigned CNT_BITS_DEF = 16;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned CFG_ADDR_W   = 4;
  localparam int unsigned IN_TDATA_W   = 8;
  localparam int unsigned OUT_TDATA_W  = 8;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST    = 16'd800;
  localparam logic [CFG_DATA_W-1:0] DOUBLE_WINDOW_RST = 16'd500;

  // Register indexes on the config port
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LONG_PRESS    = 4'd0,
    CFG_DOUBLE_WINDOW = 4'd1
  } cfg_reg_t;

  // One result item: event flags, long press in the low bit
  typedef struct packed {
    logic double_ev;
    logic long_ev;
  } bldp_evt_t;

endpackage

`default_nettype wire

>>> src/button_long_double_press_detector.sv
// Button long/double press detector: one button sample per item in, one event item out.
// Sample channel in_*, result channel out_*, register writes on cfg_*.
// The result item carries long_press_event (tdata bit 0) and double_press_event (bit 1);
// the sample item carries button_level in in_tdata bit 0 (0 = pressed).
// Registers: index 0 long press threshold (reset 800), index 1 double press window
// (reset 500), both 16 bit; writes to other indexes are ignored. cfg_ready is always high.
// Throughput: one item per clock while in_tready is high. The decision is a single pass
// of logic from the timing registers to the result register, which drives out_tvalid.
// Every sample gives exactly one result item, in order.
// When the receiver stalls, the result register and a one-deep skid stage hold up to two
// items; in_tready drops only once both are full and rises again as soon as one is taken.
// Reset (rst_n low, synchronous) empties the buffer, restores the register defaults and
// returns the timing state to button released, no press timed and no wait armed.
// COUNTER_BITS sets the width of the saturating hold and gap counters.
`default_nettype none

module button_long_double_press_detector
  import bldp_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = CNT_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Register write port
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  // Sample channel
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [0] button_level, [7:1] zero
  // Result channel
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata   // [0] long_press_event,
                                                  // [1] double_press_event, [7:2] zero
);

  logic      in_acc, can_push;
  bldp_evt_t evt, out_evt;

  assign cfg_ready = 1'b1;
  assign in_tready = can_push;
  assign in_acc    = in_tvalid && can_push;

  bldp_core #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_acc    (in_acc),
    .level     (in_tdata[0]),
    .evt       (evt)
  );

  bldp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_evt  (evt),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_evt   (out_evt)
  );

  // Pack result fields, low bit first
  assign out_tdata = {{(OUT_TDATA_W - 2){1'b0}}, out_evt.double_ev, out_evt.long_ev};

  // Upper sample bits carry nothing
  logic unused_in;
  assign unused_in = ^in_tdata[IN_TDATA_W-1:1];

endmodule

`default_nettype wire

>>> src/bldp_core.sv
// Press timing state, config registers and per-sample event decision.
// Depends on bldp_pkg and the assertion macro header.
`default_nettype none
`include "button_long_double_press_detector_macros.svh"

module bldp_core
  import bldp_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = CNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_acc,
  input  wire logic                  level,
  output bldp_evt_t                  evt
);

  localparam int unsigned CMP_W = (COUNTER_BITS > CFG_DATA_W) ? COUNTER_BITS : CFG_DATA_W;

  logic [CFG_DATA_W-1:0]   long_thr_r, win_thr_r;
  logic                    prev_level_r, press_r, await_r;
  logic [COUNTER_BITS-1:0] hold_r, gap_r;

  logic                    prev_level_nxt, press_nxt, await_nxt;
  logic [COUNTER_BITS-1:0] hold_nxt, gap_nxt;
  logic                    falling, release_ev;
  logic                    hold_long, gap_ok;
  cfg_reg_t                cfg_sel;

  assign cfg_sel = cfg_reg_t'(cfg_addr);

  // Config registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_thr_r <= LONG_PRESS_RST;
      win_thr_r  <= DOUBLE_WINDOW_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        CFG_LONG_PRESS:    long_thr_r <= cfg_wdata;
        CFG_DOUBLE_WINDOW: win_thr_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Per-sample update: saturating counters, edge detect, release decision
  always_comb begin
    gap_nxt   = gap_r;
    hold_nxt  = hold_r;
    press_nxt = press_r;
    await_nxt = await_r;
    evt       = '0;

    if (await_r && (gap_r != '1)) gap_nxt = gap_r + 1'b1;

    falling = !level && prev_level_r;
    if (falling) begin
      hold_nxt  = '0;
      press_nxt = 1'b1;
    end else if (press_r && (hold_r != '1)) begin
      hold_nxt = hold_r + 1'b1;
    end

    release_ev = level && !prev_level_r && press_nxt;
    hold_long  = CMP_W'(hold_nxt) > CMP_W'(long_thr_r);
    gap_ok     = CMP_W'(gap_nxt) <= CMP_W'(win_thr_r);

    if (release_ev) begin
      press_nxt = 1'b0;
      priority if (hold_long) begin
        evt.long_ev = 1'b1;
      end else if (!await_r) begin
        gap_nxt   = '0;
        await_nxt = 1'b1;
      end else if (gap_ok) begin
        evt.double_ev = 1'b1;
        await_nxt     = 1'b0;
      end
    end else if (await_r && !gap_ok) begin
      // window expired with no second release
      await_nxt = 1'b0;
    end

    prev_level_nxt = level;
  end

  // State registers, advanced once per accepted sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b1;
      press_r      <= 1'b0;
      await_r      <= 1'b0;
      hold_r       <= '0;
      gap_r        <= '0;
    end else if (in_acc) begin
      prev_level_r <= prev_level_nxt;
      press_r      <= press_nxt;
      await_r      <= await_nxt;
      hold_r       <= hold_nxt;
      gap_r        <= gap_nxt;
    end
  end

  // Checks
  `BLDP_NEVER(a_one_event, clk, rst_n, evt.long_ev && evt.double_ev,
              "long and double press flagged together")
  `BLDP_ASSERT(a_arm_on_sample, clk, rst_n, $rose(await_r) |-> $past(in_acc),
               "double-press wait armed without a sample")
  `BLDP_ASSERT(a_dbl_needs_arm, clk, rst_n, (in_acc && evt.double_ev) |-> await_r,
               "double press without an armed wait")
  `BLDP_ASSERT(a_press_clears, clk, rst_n, (in_acc && release_ev) |=> !press_r,
               "press still timed after release")

endmodule

`default_nettype wire

>>> src/bldp_out_buf.sv
// Two-entry output buffer (result register plus skid stage) for event items.
// Depends on bldp_pkg and the assertion macro header.
`default_nettype none
`include "button_long_double_press_detector_macros.svh"

module bldp_out_buf
  import bldp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  bldp_evt_t push_evt,
  output logic      can_push,
  output logic      out_valid,
  input  wire logic out_ready,
  output bldp_evt_t out_evt
);

  logic      main_v_r, skid_v_r;
  bldp_evt_t main_d_r, skid_d_r;
  logic      pop;

  assign can_push  = !skid_v_r;
  assign pop       = main_v_r && out_ready;
  assign out_valid = main_v_r;
  assign out_evt   = main_d_r;

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) skid_v_r <= 1'b0;
    end else if (push) begin
      if (main_v_r && !pop) skid_v_r <= 1'b1;
      else                  main_v_r <= 1'b1;
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) main_d_r <= skid_d_r;
    end else if (push) begin
      if (main_v_r && !pop) skid_d_r <= push_evt;
      else                  main_d_r <= push_evt;
    end
  end

  // Checks
  `BLDP_NEVER(a_skid_order, clk, rst_n, skid_v_r && !main_v_r,
              "skid stage holds an item while result register is empty")
  `BLDP_ASSERT(a_no_overrun, clk, rst_n, (skid_v_r && !pop) |=> skid_v_r && !can_push,
               "skid stage dropped an item")

endmodule

`default_nettype wire
